/* hw/rtl/great_circle_distance_azimuth_assert.svh */
// Assertion macros for the great circle block. Clock and reset are the
// ports of the module that uses them.
`ifndef GREAT_CIRCLE_DISTANCE_AZIMUTH_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_AZIMUTH_ASSERT_SVH

`ifndef SYNTHESIS
`define GCDA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcda: same-cycle check failed");
`define GCDA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcda: next-cycle check failed");
`else
`define GCDA_ASSERT_IMPL(lbl, ante, cons)
`define GCDA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/gcda_pkg.sv */
package gcda_pkg;

   // Angles and CORDIC vectors are Q30 radians in a 36-bit signed word.
   localparam int ANG_BITS = 30;
   localparam int AW       = 36;

   localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [AW-1:0] INV_GAIN_Q30 = 36'sd652032874;

   localparam logic signed [18:0] PI_Q16       = 19'sd205887;
   localparam logic [24:0]        DIST_MAX     = 25'd25132742;
   localparam logic [22:0]        RADIUS_RESET = 23'd6371000;

   // Register select bit of the configuration address.
   localparam logic REG_EARTH_RADIUS = 1'b0;

   localparam logic signed [AW-1:0] ATAN_Q30 [32] = '{
      36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6,
      36'sh003FEAB76, 36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55,
      36'sh0003FFFEA, 36'sh0001FFFFD, 36'sh0000FFFFF, 36'sh00007FFFF,
      36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF, 36'sh000007FFF,
      36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
      36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F,
      36'sh00000003F, 36'sh00000001F, 36'sh00000000F, 36'sh000000008,
      36'sh000000004, 36'sh000000002, 36'sh000000001, 36'sh000000000
   };

endpackage

/* hw/rtl/gcda_rot.sv */
module gcda_rot #(
   parameter int N      = 16,
   parameter int SIDE_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [gcda_pkg::AW-1:0]  in_z,
   input  logic                            in_neg,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic signed [gcda_pkg::AW-1:0]  out_x,
   output logic signed [gcda_pkg::AW-1:0]  out_y,
   output logic                            out_neg,
   output logic [SIDE_W-1:0]               out_side
);
   import gcda_pkg::*;

   logic                  v_ff    [N];
   logic signed [AW-1:0]  x_ff    [N];
   logic signed [AW-1:0]  y_ff    [N];
   logic signed [AW-1:0]  z_ff    [N];
   logic                  neg_ff  [N];
   logic [SIDE_W-1:0]     side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                 pv, pn;
      logic signed [AW-1:0] px, py, pz;
      logic [SIDE_W-1:0]    ps;
      logic signed [AW-1:0] x_in, y_in, z_in;

      if (k == 0) begin : g_first
         assign pv = in_valid;
         assign px = INV_GAIN_Q30;
         assign py = '0;
         assign pz = in_z;
         assign pn = in_neg;
         assign ps = in_side;
      end else begin : g_next
         assign pv = v_ff[k-1];
         assign px = x_ff[k-1];
         assign py = y_ff[k-1];
         assign pz = z_ff[k-1];
         assign pn = neg_ff[k-1];
         assign ps = side_ff[k-1];
      end

      // One micro-rotation towards zero residual angle.
      always_comb begin
         if (pz >= 0) begin
            x_in = px - (py >>> k);
            y_in = py + (px >>> k);
            z_in = pz - ATAN_Q30[k];
         end else begin
            x_in = px + (py >>> k);
            y_in = py - (px >>> k);
            z_in = pz + ATAN_Q30[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            neg_ff[k]  <= pn;
            side_ff[k] <= ps;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_x     = x_ff[N-1];
   assign out_y     = y_ff[N-1];
   assign out_neg   = neg_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

/* hw/rtl/gcda_sqrt.sv */
module gcda_sqrt #(
   parameter int OUT_W  = 17,
   parameter int IN_W   = 34,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_val,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [OUT_W-1:0]  out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int TW = 2 * OUT_W + 1;

   logic              v_ff    [OUT_W];
   logic [IN_W-1:0]   rem_ff  [OUT_W];
   logic [OUT_W-1:0]  root_ff [OUT_W];
   logic [SIDE_W-1:0] side_ff [OUT_W];

   // Each stage settles one root bit, most significant first, keeping the
   // remainder value minus root squared.
   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      localparam int B = OUT_W - 1 - k;
      logic              pv;
      logic [IN_W-1:0]   prem, rem_in;
      logic [OUT_W-1:0]  proot, root_in;
      logic [SIDE_W-1:0] ps;
      logic [TW-1:0]     trial;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_val;
         assign proot = '0;
         assign ps    = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign ps    = side_ff[k-1];
      end

      always_comb begin
         trial = (TW'(proot) << (B + 1)) | (TW'(1) << (2 * B));
         if (TW'(prem) >= trial) begin
            rem_in  = IN_W'(TW'(prem) - trial);
            root_in = proot | (OUT_W'(1) << B);
         end else begin
            rem_in  = prem;
            root_in = proot;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= ps;
         end
      end
   end

   assign out_valid = v_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1];
   assign out_side  = side_ff[OUT_W-1];

endmodule

/* hw/rtl/gcda_vec.sv */
module gcda_vec #(
   parameter int N         = 16,
   parameter int FRAC_BITS = 15
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [FRAC_BITS+2:0]    in_x,
   input  logic signed [FRAC_BITS+2:0]    in_y,
   output logic signed [gcda_pkg::AW-1:0] out_z
);
   import gcda_pkg::*;

   localparam int SH = ANG_BITS - FRAC_BITS;

   logic                 zero_ff [N+1];
   logic signed [AW-1:0] x_ff    [N+1];
   logic signed [AW-1:0] y_ff    [N+1];
   logic signed [AW-1:0] z_ff    [N+1];

   logic signed [AW-1:0] xs, ys, x0_in, y0_in, z0_in;

   // Left half-plane: start from plus or minus pi and mirror the vector.
   always_comb begin
      xs = AW'(in_x) <<< SH;
      ys = AW'(in_y) <<< SH;
      if (xs < 0) begin
         z0_in = (ys >= 0) ? PI_Q30 : -PI_Q30;
         x0_in = -xs;
         y0_in = -ys;
      end else begin
         z0_in = '0;
         x0_in = xs;
         y0_in = ys;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [AW-1:0] x_in, y_in, z_in;

      always_comb begin
         if (y_ff[k] >= 0) begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + ATAN_Q30[k];
         end else begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - ATAN_Q30[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
         end
      end
   end

   assign out_z = zero_ff[N] ? '0 : z_ff[N];

endmodule

/* hw/rtl/great_circle_distance_azimuth.sv */
// Great circle distance and initial azimuth between two points on a sphere.
// Each input beat carries sine and cosine of both latitudes (Q1.15) and both
// longitudes (radians, 16 fraction bits); each result beat carries the
// distance in metres for the programmed earth radius, the azimuth east of
// north and a flag for an undefined azimuth. One beat is taken every cycle
// while the pipeline is not held. The rotation CORDIC, the bit-per-stage
// square root and the vectoring CORDIC are each unrolled one step per stage.
// The whole pipeline holds while a finished result is not taken. Write the
// radius only while the block is empty.
module great_circle_distance_azimuth #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int FRAC_BITS         = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [16:0] req_sin_lat_start,
   input  logic signed [16:0] req_cos_lat_start,
   input  logic signed [18:0] req_lon_start,
   input  logic signed [16:0] req_sin_lat_end,
   input  logic signed [16:0] req_cos_lat_end,
   input  logic signed [18:0] req_lon_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [24:0]        rsp_distance_m,
   output logic signed [18:0] rsp_azimuth,
   output logic               rsp_azimuth_undefined,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import gcda_pkg::*;

   localparam int N      = CORDIC_ITERATIONS;
   localparam int VW     = FRAC_BITS + 3;
   localparam int WW     = 2 * VW;
   localparam int RB     = FRAC_BITS + 2;
   localparam int SQW    = 2 * RB;
   localparam int SH_UP  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
   localparam int SH_DN  = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
   localparam int SH_ANG = ANG_BITS - FRAC_BITS;
   localparam int AU     = AW - 1;
   localparam logic signed [WW-1:0] LIM = {{(WW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);

   function automatic logic signed [VW-1:0] sat_w(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] r;
      if (v > LIM) begin
         r = LIM;
      end else if (v < -LIM) begin
         r = -LIM;
      end else begin
         r = v;
      end
      return VW'(r);
   endfunction

   function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
      logic signed [WW-1:0] p;
      p = a * b;
      return sat_w(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [VW-1:0] trig_in(input logic signed [16:0] raw);
      logic signed [WW-1:0] w;
      w = WW'(raw);
      w = (w <<< SH_UP) >>> SH_DN;
      return sat_w(w);
   endfunction

   // Pipeline advance: everything moves unless a result at the output is not taken.
   logic en;
   logic out_valid_ff;
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // Configuration register.
   logic [22:0] radius_ff;
   logic        csr_write;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_EARTH_RADIUS) ? {9'd0, radius_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write && (paddr[2] == REG_EARTH_RADIUS)) begin
         radius_ff <= pwdata[22:0];
      end
   end

   // Entry stage: rescale trig inputs, wrap and fold the longitude difference.
   logic signed [19:0]   dlon;
   logic signed [AW-1:0] zw, z_in;
   logic                 neg_in;

   always_comb begin
      dlon = 20'(req_lon_end) - 20'(req_lon_start);
      zw   = AW'(dlon) <<< (ANG_BITS - 16);
      if (zw > PI_Q30) begin
         zw = zw - TWO_PI_Q30;
      end else if (zw < -PI_Q30) begin
         zw = zw + TWO_PI_Q30;
      end
      // Beyond a quarter turn the rotation works on the angle moved by pi.
      if (zw > HALF_PI_Q30) begin
         z_in   = zw - PI_Q30;
         neg_in = 1'b1;
      end else if (zw < -HALF_PI_Q30) begin
         z_in   = zw + PI_Q30;
         neg_in = 1'b1;
      end else begin
         z_in   = zw;
         neg_in = 1'b0;
      end
   end

   logic                 v0_ff, neg0_ff;
   logic signed [AW-1:0] z0_ff;
   logic signed [VW-1:0] sl1_0_ff, cl1_0_ff, sl2_0_ff, cl2_0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z0_ff    <= z_in;
         neg0_ff  <= neg_in;
         sl1_0_ff <= trig_in(req_sin_lat_start);
         cl1_0_ff <= trig_in(req_cos_lat_start);
         sl2_0_ff <= trig_in(req_sin_lat_end);
         cl2_0_ff <= trig_in(req_cos_lat_end);
      end
   end

   // Sine and cosine of the longitude difference.
   logic                 rot_valid, rot_neg;
   logic signed [AW-1:0] rot_x, rot_y;
   logic [4*VW-1:0]      rot_side;

   gcda_rot #(
      .N      (N),
      .SIDE_W (4 * VW)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_z      (z0_ff),
      .in_neg    (neg0_ff),
      .in_side   ({sl1_0_ff, cl1_0_ff, sl2_0_ff, cl2_0_ff}),
      .out_valid (rot_valid),
      .out_x     (rot_x),
      .out_y     (rot_y),
      .out_neg   (rot_neg),
      .out_side  (rot_side)
   );

   logic signed [VW-1:0] r_sl1, r_cl1, r_sl2, r_cl2;
   logic signed [AW-1:0] xn, yn;
   assign {r_sl1, r_cl1, r_sl2, r_cl2} = rot_side;
   assign xn = rot_neg ? -rot_x : rot_x;
   assign yn = rot_neg ? -rot_y : rot_y;

   // Product stages.
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [VW-1:0] sd1_ff, cd1_ff, cl2_1_ff, p1_1_ff, p2_1_ff, p3_1_ff, p4_1_ff;
   logic signed [VW-1:0] p1_2_ff, p3_2_ff, m2_2_ff, m4_2_ff, east_2_ff;
   logic signed [VW-1:0] cosc_3_ff, fac_3_ff, east_3_ff;
   logic signed [VW-1:0] cosc_4_ff, fac_4_ff, east_4_ff;
   logic [SQW-1:0]       esq_4_ff, fsq_4_ff;
   logic signed [VW-1:0] cosc_5_ff, fac_5_ff, east_5_ff;
   logic [SQW-1:0]       sq_5_ff;
   logic signed [WW-1:0] esq_w, fsq_w;

   assign esq_w = east_3_ff * east_3_ff;
   assign fsq_w = fac_3_ff * fac_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= rot_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd1_ff    <= sat_w(WW'(yn >>> SH_ANG));
         cd1_ff    <= sat_w(WW'(xn >>> SH_ANG));
         cl2_1_ff  <= r_cl2;
         p1_1_ff   <= fmul(r_sl1, r_sl2);
         p2_1_ff   <= fmul(r_cl1, r_cl2);
         p3_1_ff   <= fmul(r_cl1, r_sl2);
         p4_1_ff   <= fmul(r_sl1, r_cl2);

         p1_2_ff   <= p1_1_ff;
         p3_2_ff   <= p3_1_ff;
         m2_2_ff   <= fmul(p2_1_ff, cd1_ff);
         m4_2_ff   <= fmul(p4_1_ff, cd1_ff);
         east_2_ff <= fmul(cl2_1_ff, sd1_ff);

         cosc_3_ff <= sat_w(WW'(p1_2_ff) + WW'(m2_2_ff));
         fac_3_ff  <= sat_w(WW'(p3_2_ff) - WW'(m4_2_ff));
         east_3_ff <= east_2_ff;

         cosc_4_ff <= cosc_3_ff;
         fac_4_ff  <= fac_3_ff;
         east_4_ff <= east_3_ff;
         esq_4_ff  <= SQW'(esq_w);
         fsq_4_ff  <= SQW'(fsq_w);

         cosc_5_ff <= cosc_4_ff;
         fac_5_ff  <= fac_4_ff;
         east_5_ff <= east_4_ff;
         sq_5_ff   <= esq_4_ff + fsq_4_ff;
      end
   end

   // Sine of the central angle.
   logic                 sq_valid;
   logic [RB-1:0]        sq_root;
   logic [3*VW-1:0]      sq_side;
   logic signed [VW-1:0] s_cosc, s_fac, s_east;

   gcda_sqrt #(
      .OUT_W  (RB),
      .IN_W   (SQW),
      .SIDE_W (3 * VW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_val    (sq_5_ff),
      .in_side   ({cosc_5_ff, fac_5_ff, east_5_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {s_cosc, s_fac, s_east} = sq_side;

   // Central angle and azimuth run side by side.
   logic signed [AW-1:0] ang_z, az_z;

   gcda_vec #(
      .N         (N),
      .FRAC_BITS (FRAC_BITS)
   ) u_vec_ang (
      .clock (clock),
      .en    (en),
      .in_x  (s_cosc),
      .in_y  ($signed({1'b0, sq_root})),
      .out_z (ang_z)
   );

   gcda_vec #(
      .N         (N),
      .FRAC_BITS (FRAC_BITS)
   ) u_vec_az (
      .clock (clock),
      .en    (en),
      .in_x  (s_fac),
      .in_y  (s_east),
      .out_z (az_z)
   );

   logic dv_ff [N+1];
   logic du_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         du_ff[0] <= (s_east == '0) && (s_fac == '0);
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            du_ff[k+1] <= du_ff[k];
         end
      end
   end

   // Scale by the radius in two partial products, round the azimuth.
   logic [AU-1:0]        ang_u;
   logic signed [AW-1:0] az_r;
   logic signed [18:0]   az_in;

   always_comb begin
      ang_u = (ang_z < 0) ? '0 : ang_z[AU-1:0];
      az_r  = (az_z + (AW'(1) <<< (ANG_BITS - 17))) >>> (ANG_BITS - 16);
      if (du_ff[N]) begin
         az_in = '0;
      end else if (az_r > AW'(PI_Q16)) begin
         az_in = PI_Q16;
      end else if (az_r < -AW'(PI_Q16)) begin
         az_in = -PI_Q16;
      end else begin
         az_in = 19'(az_r);
      end
   end

   logic                 vf_ff, undef_f_ff;
   logic [40:0]          lo_ff;
   logic [39:0]          hi_ff;
   logic signed [18:0]   az_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= dv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff      <= 41'(ang_u[17:0]) * 41'(radius_ff);
         hi_ff      <= 40'(ang_u[AU-1:18]) * 40'(radius_ff);
         az_f_ff    <= az_in;
         undef_f_ff <= du_ff[N];
      end
   end

   logic [57:0] dist_sum;
   logic [27:0] dist_q;

   assign dist_sum = (58'(hi_ff) << 18) + 58'(lo_ff) + (58'(1) << (ANG_BITS - 1));
   assign dist_q   = dist_sum[57:30];

   // Output register.
   logic [24:0]        dist_ff;
   logic signed [18:0] az_ff;
   logic               undef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= (dist_q > 28'(DIST_MAX)) ? DIST_MAX : dist_q[24:0];
         az_ff    <= az_f_ff;
         undef_ff <= undef_f_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_distance_m        = dist_ff;
   assign rsp_azimuth           = az_ff;
   assign rsp_azimuth_undefined = undef_ff;

`include "great_circle_distance_azimuth_assert.svh"

   `GCDA_ASSERT_IMPL(a_undef_zero_az, rsp_valid && rsp_azimuth_undefined, rsp_azimuth == 19'sd0)
   `GCDA_ASSERT_IMPL(a_dist_bound, rsp_valid, rsp_distance_m <= DIST_MAX)
   `GCDA_ASSERT_NEXT(a_radius_write, csr_write && (paddr[2] == REG_EARTH_RADIUS), radius_ff == $past(pwdata[22:0]))

endmodule

/* tb/great_circle_distance_azimuth_test.sv */
`default_nettype none

module great_circle_distance_azimuth_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gcda_pkg::*;

   localparam int PIPE_LATENCY = 58;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] ADDR_EARTH_RADIUS = 3'd0;

   typedef struct {
      logic signed [16:0] sin_lat_a;
      logic signed [16:0] cos_lat_a;
      logic signed [18:0] lon_a;
      logic signed [16:0] sin_lat_b;
      logic signed [16:0] cos_lat_b;
      logic signed [18:0] lon_b;
   } point_pair_type;

   typedef struct {
      logic [24:0]        distance_m;
      logic signed [18:0] azimuth;
      logic               azimuth_undefined;
   } route_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [16:0] req_sin_lat_start = '0;
   logic signed [16:0] req_cos_lat_start = '0;
   logic signed [18:0] req_lon_start = '0;
   logic signed [16:0] req_sin_lat_end = '0;
   logic signed [16:0] req_cos_lat_end = '0;
   logic signed [18:0] req_lon_end = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [24:0] rsp_distance_m;
   logic signed [18:0] rsp_azimuth;
   logic rsp_azimuth_undefined;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   great_circle_distance_azimuth dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   point_pair_type pending_pairs[$];
   route_type      expected_routes[$];
   logic [22:0] radius_m = RADIUS_RESET;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // Predictor arithmetic: Q15 trig values, Q30 angles, floor shifts throughout.
   function automatic longint sat2(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return sat2((a * b) >>> 15);
   endfunction

   function automatic void rotate_sincos(longint z, output longint s, output longint c);
      longint x, y, nx, ny, step;
      bit flip;
      x = INV_GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > longint'(HALF_PI_Q30)) begin
         z -= PI_Q30;
         flip = 1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
         z += PI_Q30;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         step = ATAN_Q30[i];
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= step;
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += step;
         end
         x = nx;
         y = ny;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      s = sat2(y >>> 15);
      c = sat2(x >>> 15);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, nx, ny, step;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 32768;
      y = y * 32768;
      if (x < 0) begin
         z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         step = ATAN_Q30[i];
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += step;
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= step;
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic route_type predict_route(point_pair_type p, logic [22:0] radius);
      longint sl1, cl1, sl2, cl2, z, sd, cd, cos_c, north, east, sin_c, ang, az;
      longint unsigned dist_m;
      route_type r;
      sl1 = sat2(longint'(p.sin_lat_a));
      cl1 = sat2(longint'(p.cos_lat_a));
      sl2 = sat2(longint'(p.sin_lat_b));
      cl2 = sat2(longint'(p.cos_lat_b));
      z = (longint'(p.lon_b) - longint'(p.lon_a)) * 16384;
      while (z > longint'(PI_Q30)) z -= TWO_PI_Q30;
      while (z < -longint'(PI_Q30)) z += TWO_PI_Q30;
      rotate_sincos(z, sd, cd);
      cos_c = sat2(qmul(sl1, sl2) + qmul(qmul(cl1, cl2), cd));
      north = sat2(qmul(cl1, sl2) - qmul(qmul(sl1, cl2), cd));
      east = qmul(cl2, sd);
      sin_c = floor_sqrt(east * east + north * north);
      ang = vector_angle(sin_c, cos_c);
      if (ang < 0) ang = 0;
      dist_m = (longint'(ang) * longint'({1'b0, radius}) + (64'd1 << 29)) >> 30;
      if (dist_m > DIST_MAX) dist_m = DIST_MAX;
      r.distance_m = dist_m[24:0];
      if (east == 0 && north == 0) begin
         r.azimuth_undefined = 1'b1;
         r.azimuth = '0;
      end else begin
         az = (vector_angle(east, north) + (64'sd1 << 13)) >>> 14;
         if (az > longint'(PI_Q16)) az = PI_Q16;
         if (az < -longint'(PI_Q16)) az = -longint'(PI_Q16);
         r.azimuth_undefined = 1'b0;
         r.azimuth = az[18:0];
      end
      return r;
   endfunction

   // Sender: a new beat is presented only once the current one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_routes.push_back(predict_route('{req_sin_lat_start, req_cos_lat_start,
               req_lon_start, req_sin_lat_end, req_cos_lat_end, req_lon_end}, radius_m));
         if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            point_pair_type p;
            p = pending_pairs.pop_front();
            req_sin_lat_start <= p.sin_lat_a;
            req_cos_lat_start <= p.cos_lat_a;
            req_lon_start     <= p.lon_a;
            req_sin_lat_end   <= p.sin_lat_b;
            req_cos_lat_end   <= p.cos_lat_b;
            req_lon_end       <= p.lon_b;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_routes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: distance %0d azimuth %0d undefined %0b",
                     rsp_distance_m, rsp_azimuth, rsp_azimuth_undefined);
            end else begin
               route_type e;
               e = expected_routes.pop_front();
               if (e.distance_m !== rsp_distance_m || e.azimuth !== rsp_azimuth ||
                   e.azimuth_undefined !== rsp_azimuth_undefined) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        e.distance_m, e.azimuth, e.azimuth_undefined,
                        rsp_distance_m, rsp_azimuth, rsp_azimuth_undefined);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("great_circle_distance_azimuth_test: FAIL");
         $finish;
      end
   end

   task automatic write_radius(logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_EARTH_RADIUS;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      radius_m = value[22:0];
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0 || req_valid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic signed [16:0] pick_trig();
      case ($urandom_range(9))
         7, 8:    return 17'($urandom());
         9:       return ($urandom_range(1) != 0) ? 17'sd32768 : -17'sd32768;
         default: return 17'(int'($urandom_range(65536)) - 32768);
      endcase
   endfunction

   function automatic logic signed [18:0] pick_lon();
      case ($urandom_range(9))
         8:       return 19'($urandom());
         9:       return ($urandom_range(1) != 0) ? PI_Q16 : -PI_Q16;
         default: return 19'(int'($urandom_range(411774)) - 205887);
      endcase
   endfunction

   task automatic queue_random(int count);
      point_pair_type p;
      for (int n = 0; n < count; n++) begin
         p.sin_lat_a = pick_trig();
         p.cos_lat_a = pick_trig();
         p.lon_a     = pick_lon();
         p.sin_lat_b = pick_trig();
         p.cos_lat_b = pick_trig();
         p.lon_b     = pick_lon();
         // A few beats repeat the start point, which gives a zero distance.
         if ($urandom_range(19) == 0) begin
            p.sin_lat_b = p.sin_lat_a;
            p.cos_lat_b = p.cos_lat_a;
            p.lon_b = p.lon_a;
         end
         pending_pairs.push_back(p);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_radius(RADIUS_RESET);
      sender_idle_pct = 23;
      receiver_idle_pct = 67;
      // Zero terms, identical points, poles, antipodes, wraps and field extremes.
      pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
      pending_pairs.push_back('{0, 32768, 0, 0, 32768, 0});
      pending_pairs.push_back('{0, 32768, 0, 0, 32768, 205887});
      pending_pairs.push_back('{0, 32768, -205887, 0, 32768, 205887});
      pending_pairs.push_back('{32768, 0, 0, -32768, 0, 0});
      pending_pairs.push_back('{32768, 0, 1000, 32768, 0, -1000});
      pending_pairs.push_back('{0, 32768, 0, 32768, 0, 0});
      pending_pairs.push_back('{0, 32768, 0, 0, 32768, 102943});
      pending_pairs.push_back('{0, 32768, 0, 0, 32768, -102943});
      pending_pairs.push_back('{0, 32768, 0, 0, 32768, -102945});
      pending_pairs.push_back('{0, 32768, 205887, 0, 32768, -205887});
      pending_pairs.push_back('{0, 32768, -262144, 0, 32768, 262143});
      pending_pairs.push_back('{0, 32768, 262143, 0, 32768, -262144});
      pending_pairs.push_back('{-65536, 65535, 0, 65535, -65536, 100});
      pending_pairs.push_back('{65535, 65535, 262143, 65535, 65535, 262143});
      pending_pairs.push_back('{-65536, -65536, -262144, -65536, -65536, 0});
      pending_pairs.push_back('{23170, 23170, 0, -23170, 23170, 51472});
      pending_pairs.push_back('{-32768, 0, 0, 32768, 0, 50000});
      pending_pairs.push_back('{16384, 28378, -100000, -16384, 28378, 150000});
      pending_pairs.push_back('{0, -32768, 0, 0, 32768, 0});
      drain();

      write_radius(23'd8000000);
      queue_random(110);
      drain();
      write_radius(32'd1);
      queue_random(100);
      drain();

      sender_idle_pct = 67;
      receiver_idle_pct = 23;
      write_radius($urandom_range(8000000, 1));
      queue_random(110);
      drain();
      write_radius(32'd0);
      queue_random(100);
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      // Bits above the register width are dropped by the block.
      write_radius(32'hFFFF_FFFF);
      queue_random(110);
      drain();
      write_radius(RADIUS_RESET);
      queue_random(110);
      drain();

      if (mismatches == 0 && expected_routes.size() == 0)
         $display("great_circle_distance_azimuth_test: PASS");
      else
         $display("great_circle_distance_azimuth_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/gcda_pkg.sv
hw/rtl/gcda_rot.sv
hw/rtl/gcda_sqrt.sv
hw/rtl/gcda_vec.sv
hw/rtl/great_circle_distance_azimuth.sv
tb/great_circle_distance_azimuth_test.sv
